// ===== sv/iis_pkg.sv =====
// Shared types and constants for the integer index sort block.
package iis_pkg;

   localparam int TAG_WIDTH     = 6;
   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_WIDTH_DEF = 32;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic occupied;
      logic at_end;
   } cell_ctl_type;

endpackage

// ===== sv/iis_cell.sv =====
// One cell of the insertion chain: holds a key and its tag.
module iis_cell #(
   parameter int KEY_WIDTH = iis_pkg::KEY_WIDTH_DEF
) (
   input  logic                           clock,
   input  iis_pkg::cell_ctl_type          ctl,
   input  logic signed [KEY_WIDTH-1:0]    new_key,
   input  logic [iis_pkg::TAG_WIDTH-1:0]  new_tag,
   input  logic signed [KEY_WIDTH-1:0]    left_key,
   input  logic [iis_pkg::TAG_WIDTH-1:0]  left_tag,
   input  logic                           left_gt,
   input  logic signed [KEY_WIDTH-1:0]    right_key,
   input  logic [iis_pkg::TAG_WIDTH-1:0]  right_tag,
   output logic signed [KEY_WIDTH-1:0]    key,
   output logic [iis_pkg::TAG_WIDTH-1:0]  tag,
   output logic                           gt
);
   import iis_pkg::*;

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic signed [KEY_WIDTH-1:0] key_in;
   logic [TAG_WIDTH-1:0]        tag_ff;
   logic [TAG_WIDTH-1:0]        tag_in;

   // strictly greater: equal keys stay ahead, keeping arrival order
   assign gt  = ctl.occupied && (key_ff > new_key);
   assign key = key_ff;
   assign tag = tag_ff;

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctl.shift) begin
         key_in = right_key;
         tag_in = right_tag;
      end else if (ctl.insert && (gt || ctl.at_end)) begin
         if (left_gt) begin
            key_in = left_key;
            tag_in = left_tag;
         end else begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// ===== sv/integer_index_sort.sv =====
// Stable index sort top level: insertion chain of cells, then drain in key order.
// Loading: one key per cycle, busy stays low until the key marked last is taken.
// Emission: one result per stored key per cycle as the chain shifts towards cell 0;
// busy is high until every stored key (1 to MAX_ITEMS) is emitted; the next load may start after.
// Reset clears the fill count, overflow flag, mode register and state; cells need none.
// Results are strobed for one cycle each; the receiver cannot stall them.
module integer_index_sort #(
   parameter int MAX_ITEMS = iis_pkg::MAX_ITEMS_DEF,
   parameter int KEY_WIDTH = iis_pkg::KEY_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [KEY_WIDTH-1:0]    req_key,
   input  logic [iis_pkg::TAG_WIDTH-1:0]  req_tag,
   input  logic                           req_last_in,
   output logic                           rsp_strobe,
   output logic [iis_pkg::TAG_WIDTH-1:0]  rsp_sorted_tag,
   output logic signed [KEY_WIDTH-1:0]    rsp_sorted_key,
   output logic                           rsp_last_out,
   output logic                           rsp_overflow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data
);
   import iis_pkg::*;

   localparam int FILL_WIDTH = $clog2(MAX_ITEMS + 1);
   localparam logic [FILL_WIDTH-1:0] FULL = FILL_WIDTH'(MAX_ITEMS);
   localparam logic [FILL_WIDTH-1:0] ONE  = FILL_WIDTH'(1);

   state_type             state_ff;
   state_type             state_in;
   logic [FILL_WIDTH-1:0] fill_ff;
   logic [FILL_WIDTH-1:0] fill_in;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic                  use_given_tags_ff;
   logic                  insert;
   logic                  shift;
   logic                  accept;
   logic [TAG_WIDTH-1:0]  new_tag;

   logic signed [KEY_WIDTH-1:0] cell_key [MAX_ITEMS];
   logic [TAG_WIDTH-1:0]        cell_tag [MAX_ITEMS];
   logic                        cell_gt  [MAX_ITEMS];

   assign busy      = (state_ff == ST_EMIT);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign new_tag   = use_given_tags_ff ? req_tag : TAG_WIDTH'(fill_ff);

   assign rsp_strobe     = (state_ff == ST_EMIT);
   assign rsp_sorted_key = cell_key[0];
   assign rsp_sorted_tag = cell_tag[0];
   assign rsp_last_out   = (fill_ff == ONE);
   assign rsp_overflow   = ovf_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      insert   = 1'b0;
      shift    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (fill_ff != FULL) begin
                  insert  = 1'b1;
                  fill_in = fill_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            shift   = 1'b1;
            fill_in = fill_ff - ONE;
            if (fill_ff == ONE) begin
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_LOAD;
         fill_ff           <= '0;
         ovf_ff            <= 1'b0;
         use_given_tags_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         if (csr_valid && csr_ready) begin
            use_given_tags_ff <= csr_data;
         end
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      localparam logic [FILL_WIDTH-1:0] IDX = FILL_WIDTH'(i);
      cell_ctl_type                ctl;
      logic signed [KEY_WIDTH-1:0] left_key;
      logic [TAG_WIDTH-1:0]        left_tag;
      logic                        left_gt;
      logic signed [KEY_WIDTH-1:0] right_key;
      logic [TAG_WIDTH-1:0]        right_tag;

      assign ctl.insert   = insert;
      assign ctl.shift    = shift;
      assign ctl.occupied = (IDX < fill_ff);
      assign ctl.at_end   = (IDX == fill_ff);

      if (i == 0) begin : g_first
         assign left_key = req_key;
         assign left_tag = new_tag;
         assign left_gt  = 1'b0;
      end else begin : g_inner
         assign left_key = cell_key[i-1];
         assign left_tag = cell_tag[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_key = cell_key[i];
         assign right_tag = cell_tag[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
         assign right_tag = cell_tag[i+1];
      end

      iis_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_key   (req_key),
         .new_tag   (new_tag),
         .left_key  (left_key),
         .left_tag  (left_tag),
         .left_gt   (left_gt),
         .right_key (right_key),
         .right_tag (right_tag),
         .key       (cell_key[i]),
         .tag       (cell_tag[i]),
         .gt        (cell_gt[i])
      );
   end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the integer index sort block: stable order, tags, overflow.
module tb_top;
   import iis_pkg::*;

   localparam int BANK_DEPTH = 64;
   localparam int KEY_BITS   = 32;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]       tag;
      logic signed [KEY_BITS-1:0] key;
      logic                       last;
      logic                       dropped;
   } ranked_key_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [KEY_BITS-1:0] req_key;
   logic [TAG_WIDTH-1:0]       req_tag;
   logic                       req_last_in;
   logic                       rsp_strobe;
   logic [TAG_WIDTH-1:0]       rsp_sorted_tag;
   logic signed [KEY_BITS-1:0] rsp_sorted_key;
   logic                       rsp_last_out;
   logic                       rsp_overflow;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_data;

   // predictor state
   logic signed [KEY_BITS-1:0] bank_keys [BANK_DEPTH];
   logic [TAG_WIDTH-1:0]       bank_tags [BANK_DEPTH];
   int                         fill_level;
   bit                         dropped_seen;
   bit                         given_tags;

   ranked_key_type             pending_ranks [$];
   ranked_key_type             head_rank;
   int                         max_gap;
   int                         error_count;

   localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
   localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

   integer_index_sort #(
      .MAX_ITEMS(BANK_DEPTH),
      .KEY_WIDTH(KEY_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_key       (req_key),
      .req_tag       (req_tag),
      .req_last_in   (req_last_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_sorted_tag(rsp_sorted_tag),
      .rsp_sorted_key(rsp_sorted_key),
      .rsp_last_out  (rsp_last_out),
      .rsp_overflow  (rsp_overflow),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      if (error_count < 100)
         $display("error at %0t: %s got %0d want %0d", $time, field, got, want);
      error_count++;
   endtask

   // Load one key into the model bank; on the last key, rank the bank stably.
   function automatic void load_key(input logic signed [KEY_BITS-1:0] key,
                                    input logic [TAG_WIDTH-1:0] tag, input bit last);
      int             order [BANK_DEPTH];
      int             n;
      int             j;
      ranked_key_type r;
      if (fill_level < BANK_DEPTH) begin
         bank_keys[fill_level] = key;
         bank_tags[fill_level] = given_tags ? tag : fill_level[TAG_WIDTH-1:0];
         fill_level++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (!last)
         return;
      n = fill_level;
      for (int i = 0; i < n; i++) begin
         j = i;
         while (j > 0 && bank_keys[order[j-1]] > bank_keys[i]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int i = 0; i < n; i++) begin
         r.tag     = bank_tags[order[i]];
         r.key     = bank_keys[order[i]];
         r.last    = (i == n - 1);
         r.dropped = dropped_seen;
         pending_ranks.push_back(r);
      end
      fill_level   = 0;
      dropped_seen = 1'b0;
   endfunction

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 8)) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // start is only lowered ahead of a gap, so back-to-back transfers keep it high
   task automatic send_key(input logic signed [KEY_BITS-1:0] key,
                           input logic [TAG_WIDTH-1:0] tag, input bit last);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_key     <= key;
      req_tag     <= tag;
      req_last_in <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      load_key(key, tag, last);
   endtask

   task automatic send_random_set(input int count);
      for (int i = 0; i < count; i++)
         send_key(pick_key(), TAG_WIDTH'($urandom_range(0, 63)), i == count - 1);
   endtask

   task automatic settle_sets();
      start <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tag_mode(input bit mode);
      settle_sets();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      given_tags = mode;
      csr_valid <= 1'b0;
   endtask

   // position tags straight after reset, lone extremes, duplicates across the range
   task automatic test_position_tags();
      logic signed [KEY_BITS-1:0] keys [8];
      keys = '{KEY_MAX, KEY_MIN, 0, -1, 1, KEY_MAX, KEY_MIN, 0};
      max_gap = 0;
      send_key(KEY_MIN, 6'h3f, 1'b1);
      send_key(KEY_MAX, 6'h00, 1'b1);
      for (int i = 0; i < 8; i++)
         send_key(keys[i], i[0] ? 6'h3f : 6'h00, i == 7);
   endtask

   task automatic test_given_tags();
      logic signed [KEY_BITS-1:0] keys [7];
      logic [TAG_WIDTH-1:0]       tags [7];
      keys = '{5, 5, -5, 5, -5, KEY_MIN, KEY_MAX};
      tags = '{6'd63, 6'd0, 6'd42, 6'd21, 6'd1, 6'd62, 6'd7};
      write_tag_mode(1'b1);
      max_gap = 8;
      for (int i = 0; i < 7; i++)
         send_key(keys[i], tags[i], i == 6);
      write_tag_mode(1'b0);
   endtask

   // exactly full, then past full with the last key itself dropped
   task automatic test_bank_limits();
      max_gap = 2;
      send_random_set(BANK_DEPTH);
      write_tag_mode(1'b1);
      max_gap = 0;
      send_random_set(BANK_DEPTH + 3);
   endtask

   task automatic test_random_sets();
      int sent;
      int count;
      sent = 0;
      while (sent < 16) begin
         case ($urandom_range(0, 9))
            0:       count = $urandom_range(40, BANK_DEPTH + 2);
            1, 2:    count = $urandom_range(9, 24);
            default: count = $urandom_range(1, 8);
         endcase
         if ($urandom_range(0, 2) == 0)
            write_tag_mode(1'($urandom_range(0, 1)));
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
         send_random_set(count);
         sent += count;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_ranks.size() == 0) begin
            report_mismatch("unexpected result, sorted_key", rsp_sorted_key, 0);
         end else begin
            head_rank = pending_ranks.pop_front();
            if (rsp_sorted_tag !== head_rank.tag)
               report_mismatch("sorted_tag", rsp_sorted_tag, head_rank.tag);
            if (rsp_sorted_key !== head_rank.key)
               report_mismatch("sorted_key", rsp_sorted_key, head_rank.key);
            if (rsp_last_out !== head_rank.last)
               report_mismatch("last_out", rsp_last_out, head_rank.last);
            if (rsp_overflow !== head_rank.dropped)
               report_mismatch("overflow", rsp_overflow, head_rank.dropped);
         end
      end
   end

   initial begin
      error_count  = 0;
      fill_level   = 0;
      dropped_seen = 1'b0;
      given_tags   = 1'b0;
      max_gap      = 0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_key     <= '0;
      req_tag     <= '0;
      req_last_in <= 1'b0;
      csr_valid   <= 1'b0;
      csr_data    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_position_tags();
      test_given_tags();
      test_bank_limits();
      test_random_sets();

      settle_sets();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
